>>> design/joystick_deadzone_expo_conditioner_defines.svh
// Assertion macros for the joystick dead-zone and expo conditioner
`ifndef JOYSTICK_DEADZONE_EXPO_CONDITIONER_DEFINES_SVH
`define JOYSTICK_DEADZONE_EXPO_CONDITIONER_DEFINES_SVH

`ifndef ASSERT_OFF
`define JDEC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define JDEC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define JDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JDEC_ASSERT(lbl, cond, msg)
`define JDEC_ASSERT_IMP(lbl, ante, cons, msg)
`define JDEC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/jdec_pkg.sv
// Shared constants, register indexes and types of the stick conditioner
package jdec_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int MAX_POWER     = 4;

    localparam int RAW_W   = 8;
    localparam int A_W     = 7;
    localparam int PW_W    = 3;
    localparam int MIX_W   = 9;
    localparam int OUT_W   = 16;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 3;

    // magnitude holds up to ONE, signed state one bit more
    localparam int MAG_W     = FRACTION_BITS + 1;
    localparam int STATE_W   = FRACTION_BITS + 2;
    localparam int MUL_B_W   = (FRACTION_BITS > MIX_W) ? FRACTION_BITS : MIX_W;
    localparam int PROD_W    = FRACTION_BITS + MUL_B_W;
    localparam int DIV_CNT_W = $clog2(FRACTION_BITS + 1);

    localparam logic [MAG_W-1:0] ONE = MAG_W'(1) << FRACTION_BITS;
    localparam logic [MIX_W-1:0] MIX_FULL = MIX_W'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_DZ_INNER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DZ_OUTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH   = 3'd4;

    typedef struct packed {
        logic           start;
        logic [A_W-1:0] dividend;
        logic [A_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic [FRACTION_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

>>> design/jdec_if.sv
// Handshake channels: raw stick samples in, conditioned axes out
interface jdec_in_if;
    import jdec_pkg::*;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;

    modport source (output valid, output raw_x, output raw_y, input ready);
    modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

interface jdec_out_if;
    import jdec_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] cond_x;
    logic signed [OUT_W-1:0] cond_y;

    modport source (output valid, output cond_x, output cond_y, input ready);
    modport sink   (input valid, input cond_x, input cond_y, output ready);
endinterface

>>> design/joystick_deadzone_expo_conditioner.sv
// Top level: two-axis stick dead-zone, expo curve and smoothing sequencer
// Per axis, a sample in a dead zone or at full scale skips the divider; any other runs the
//   serial divider, then, when the curve is on, the power loop and the mix steps.
// Item: both axes in turn, then the output step, which waits until the output is free;
//   no new sample is taken until the sequencer is back in idle.
// The serial divider and the single shared multiplier set how long each sample takes.
// Reset: registers at 15/0/2/128/0, smoothing history of both axes zero, output empty.
`include "joystick_deadzone_expo_conditioner_defines.svh"
module joystick_deadzone_expo_conditioner (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [jdec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jdec_pkg::CFG_W-1:0]        cfg_data,
    jdec_in_if.sink                           stick,
    jdec_out_if.source                        cond
);
    import jdec_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FOLD  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_POW   = 3'd3;
    localparam logic [2:0] S_MIXA  = 3'd4;
    localparam logic [2:0] S_MIXB  = 3'd5;
    localparam logic [2:0] S_STORE = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // configuration
    logic [A_W-1:0]   dz_inner_reg;
    logic [A_W-1:0]   dz_outer_reg;
    logic [PW_W-1:0]  power_reg;
    logic [MIX_W-1:0] mix_reg;
    logic             smooth_reg;

    // sequencer and datapath
    logic [2:0]               state_reg, state_next;
    logic                     axis_reg, axis_next;
    logic [RAW_W-1:0]         raw_x_reg, raw_y_reg;
    logic                     neg_reg, neg_next;
    logic [FRACTION_BITS-1:0] x_reg, x_next;
    logic [FRACTION_BITS-1:0] p_reg, p_next;
    logic [PW_W-1:0]          k_reg, k_next;
    logic [PROD_W-1:0]        acc_reg, acc_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic signed [STATE_W-1:0] prev_reg [2];
    logic signed [STATE_W-1:0] res_reg [2];
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  out_x_reg, out_y_reg;

    logic [RAW_W-1:0]         raw_sel;
    logic                     fold_neg;
    logic [A_W-1:0]           fold_a;
    logic [A_W-1:0]           range_r;
    logic [MIX_W-1:0]         mix_eff;
    logic [PW_W-1:0]          pw_eff;
    logic                     curve_on;
    logic [FRACTION_BITS-1:0] mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [PROD_W-1:0]        prod;
    logic [PROD_W:0]          mix_sum;
    logic signed [STATE_W-1:0] y_signed;
    logic signed [STATE_W:0]   smooth_sum;
    logic signed [STATE_W-1:0] smooth_val;
    logic                     out_free;

    div_req_t div_req;
    div_rsp_t div_rsp;

    jdec_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_inner_reg <= A_W'(15);
            dz_outer_reg <= '0;
            power_reg    <= PW_W'(2);
            mix_reg      <= MIX_W'(128);
            smooth_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DZ_INNER: dz_inner_reg <= cfg_data[A_W-1:0];
                CFG_DZ_OUTER: dz_outer_reg <= cfg_data[A_W-1:0];
                CFG_POWER:    power_reg    <= cfg_data[PW_W-1:0];
                CFG_MIX:      mix_reg      <= cfg_data[MIX_W-1:0];
                CFG_SMOOTH:   smooth_reg   <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign mix_eff  = (mix_reg > MIX_FULL) ? MIX_FULL : mix_reg;
    assign pw_eff   = (power_reg > PW_W'(MAX_POWER)) ? PW_W'(MAX_POWER) : power_reg;
    assign curve_on = (mix_eff != '0) && (pw_eff > PW_W'(1));

    // fold: 127 - v is ~v[6:0] below center, v - 128 is v[6:0] above
    assign raw_sel  = axis_reg ? raw_y_reg : raw_x_reg;
    assign fold_neg = ~raw_sel[RAW_W-1];
    assign fold_a   = fold_neg ? ~raw_sel[A_W-1:0] : raw_sel[A_W-1:0];
    assign range_r  = ~dz_outer_reg;

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            S_MIXA:
            begin
                mul_a = p_reg;
                mul_b = MUL_B_W'(mix_eff);
            end
            S_MIXB:
            begin
                mul_a = x_reg;
                mul_b = MUL_B_W'(MIX_FULL - mix_eff);
            end
            default:
            begin
                mul_a = p_reg;
                mul_b = MUL_B_W'(x_reg);
            end
        endcase
    end

    assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign mix_sum = {1'b0, acc_reg} + {1'b0, prod};

    assign y_signed   = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    assign smooth_sum = (STATE_W + 1)'(y_signed) + (STATE_W + 1)'(prev_reg[axis_reg]);
    assign smooth_val = smooth_sum[STATE_W:1];

    assign out_free = !out_valid_reg || cond.ready;

    always_comb
    begin
        state_next       = state_reg;
        axis_next        = axis_reg;
        neg_next         = neg_reg;
        x_next           = x_reg;
        p_next           = p_reg;
        k_next           = k_reg;
        acc_next         = acc_reg;
        mag_next         = mag_reg;
        div_req.start    = 1'b0;
        div_req.dividend = fold_a - dz_inner_reg;
        div_req.divisor  = range_r - dz_inner_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (stick.valid)
                begin
                    state_next = S_FOLD;
                    axis_next  = 1'b0;
                end
            end
            S_FOLD:
            begin
                neg_next = fold_neg;
                if (fold_a <= dz_inner_reg)
                begin
                    mag_next   = '0;
                    state_next = S_STORE;
                end
                else if (fold_a >= range_r)
                begin
                    mag_next   = ONE;
                    state_next = S_STORE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    x_next = div_rsp.quotient;
                    p_next = div_rsp.quotient;
                    k_next = PW_W'(1);
                    if (curve_on)
                    begin
                        state_next = S_POW;
                    end
                    else
                    begin
                        mag_next   = MAG_W'(div_rsp.quotient);
                        state_next = S_STORE;
                    end
                end
            end
            S_POW:
            begin
                p_next = prod[FRACTION_BITS +: FRACTION_BITS];
                k_next = k_reg + 1'b1;
                if (k_next == pw_eff)
                begin
                    state_next = S_MIXA;
                end
            end
            S_MIXA:
            begin
                acc_next   = prod;
                state_next = S_MIXB;
            end
            S_MIXB:
            begin
                mag_next   = mix_sum[8 +: MAG_W];
                state_next = S_STORE;
            end
            S_STORE:
            begin
                if (axis_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    axis_next  = 1'b1;
                    state_next = S_FOLD;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_reg[0]   <= '0;
            prev_reg[1]   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            if (state_reg == S_STORE && smooth_reg)
            begin
                prev_reg[axis_reg] <= smooth_val;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cond.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        x_reg   <= x_next;
        p_reg   <= p_next;
        k_reg   <= k_next;
        acc_reg <= acc_next;
        mag_reg <= mag_next;
        if (stick.valid && stick.ready)
        begin
            raw_x_reg <= stick.raw_x;
            raw_y_reg <= stick.raw_y;
        end
        if (state_reg == S_STORE)
        begin
            res_reg[axis_reg] <= smooth_reg ? smooth_val : y_signed;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_x_reg <= OUT_W'(res_reg[0]);
            out_y_reg <= OUT_W'(res_reg[1]);
        end
    end

    assign stick.ready = (state_reg == S_IDLE);
    assign cond.valid  = out_valid_reg;
    assign cond.cond_x = out_x_reg;
    assign cond.cond_y = out_y_reg;

    `JDEC_ASSERT_NEXT(a_accept_folds, stick.valid && stick.ready, state_reg == S_FOLD, "accepted sample did not start the x axis")
    `JDEC_ASSERT_IMP(a_div_start_fold, div_req.start, state_reg == S_FOLD, "divider started outside fold step")
    `JDEC_ASSERT_IMP(a_pow_count, state_reg == S_POW, k_reg < pw_eff && curve_on, "power loop overran exponent")
    `JDEC_ASSERT_IMP(a_mag_range, state_reg == S_STORE, mag_reg <= ONE, "axis magnitude above full scale")
    `JDEC_ASSERT_IMP(a_done_waiting, div_rsp.done, state_reg == S_DIV, "divider result with no one waiting")

endmodule

>>> design/jdec_div.sv
// Restoring divider: (dividend << FRACTION_BITS) / divisor, one quotient bit a cycle
module jdec_div (
    input  logic               clk,
    input  logic               rst_n,
    input  jdec_pkg::div_req_t req,
    output jdec_pkg::div_rsp_t rsp
);
    import jdec_pkg::*;

    logic [A_W-1:0]           rem_reg, rem_next;
    logic [A_W-1:0]           dvs_reg;
    logic [FRACTION_BITS-1:0] q_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [A_W:0]             rem_sh;
    logic                     q_bit;

    // dividend is below divisor, so the remainder always fits A_W bits
    always_comb
    begin
        rem_sh = {rem_reg, 1'b0};
        q_bit  = rem_sh >= {1'b0, dvs_reg};
        if (q_bit)
        begin
            rem_next = A_W'(rem_sh - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = rem_sh[A_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(FRACTION_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend;
            dvs_reg <= req.divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[FRACTION_BITS-2:0], q_bit};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule
